>>> hw/rtl/tsc_pkg.sv
// Shared types, constants and the CRC-8 step function for the scratchpad converter.
package tsc_pkg;

   // Scratchpad layout.
   localparam int unsigned FRAME_BYTES = 9;
   localparam int unsigned IDX_WIDTH = 4;

   localparam logic [IDX_WIDTH-1:0] IDX_TEMP_LOW = 4'd0;
   localparam logic [IDX_WIDTH-1:0] IDX_TEMP_HIGH = 4'd1;
   localparam logic [IDX_WIDTH-1:0] IDX_RESOLUTION = 4'd4;
   localparam logic [IDX_WIDTH-1:0] IDX_COUNT_REMAIN = 4'd6;
   localparam logic [IDX_WIDTH-1:0] IDX_LAST = IDX_WIDTH'(FRAME_BYTES - 1);

   // Sensor family codes.
   localparam logic [7:0] FAMILY_NINE_BIT = 8'h10;
   localparam logic [7:0] FAMILY_TWELVE_BIT = 8'h28;

   // Reflected Dallas polynomial.
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // Width of the converted temperature.
   localparam int unsigned CENTI_WIDTH = 15;

   // Frame tracker status seen by the converter and the control logic.
   typedef struct packed {
      logic       last_byte;
      logic       crc_ok;
      logic [7:0] temp_low;
      logic [7:0] temp_high;
      logic [7:0] resolution;
      logic [7:0] count_remain;
   } frame_status_type;

   // One byte of the running CRC-8, bit at a time, LSB first.
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/tsc_frame.sv
// Frame tracker: byte count, running CRC and the held scratchpad bytes.
module tsc_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      frame_start,
   input  logic [7:0]                scratch_byte,
   output tsc_pkg::frame_status_type status
);
   import tsc_pkg::*;

   logic [IDX_WIDTH-1:0] byte_index_ff;
   logic [IDX_WIDTH-1:0] byte_index_in;
   logic [7:0]           running_crc_ff;
   logic [7:0]           running_crc_in;
   logic [7:0]           temp_low_ff;
   logic [7:0]           temp_high_ff;
   logic [7:0]           resolution_ff;
   logic [7:0]           count_remain_ff;

   logic [IDX_WIDTH-1:0] idx_cur;
   logic [7:0]           crc_base;
   logic [7:0]           crc_next;
   logic                 last_byte;

   // A frame start restarts the count and the CRC for this byte.
   always_comb begin
      idx_cur   = frame_start ? '0 : byte_index_ff;
      crc_base  = frame_start ? 8'h00 : running_crc_ff;
      crc_next  = crc_update(crc_base, scratch_byte);
      last_byte = (idx_cur >= IDX_LAST);
   end

   // Next count and CRC; both return to zero after the last byte.
   always_comb begin
      byte_index_in  = byte_index_ff;
      running_crc_in = running_crc_ff;
      if (step) begin
         if (last_byte) begin
            byte_index_in  = '0;
            running_crc_in = 8'h00;
         end else begin
            byte_index_in  = idx_cur + IDX_WIDTH'(1);
            running_crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         running_crc_ff <= 8'h00;
      end else begin
         byte_index_ff  <= byte_index_in;
         running_crc_ff <= running_crc_in;
      end
   end

   // Held bytes are captured at their place in the frame.
   always_ff @(posedge clock) begin
      if (step) begin
         if (idx_cur == IDX_TEMP_LOW) begin
            temp_low_ff <= scratch_byte;
         end
         if (idx_cur == IDX_TEMP_HIGH) begin
            temp_high_ff <= scratch_byte;
         end
         if (idx_cur == IDX_RESOLUTION) begin
            resolution_ff <= scratch_byte;
         end
         if (idx_cur == IDX_COUNT_REMAIN) begin
            count_remain_ff <= scratch_byte;
         end
      end
   end

   always_comb begin
      status.last_byte    = last_byte;
      status.crc_ok       = (crc_next == 8'h00);
      status.temp_low     = temp_low_ff;
      status.temp_high    = temp_high_ff;
      status.resolution   = resolution_ff;
      status.count_remain = count_remain_ff;
   end

endmodule

>>> hw/rtl/tsc_convert.sv
// Raw reading to centi-Celsius conversion for both sensor families.
module tsc_convert (
   input  logic [7:0]                      family_code,
   input  tsc_pkg::frame_status_type       status,
   output logic signed [tsc_pkg::CENTI_WIDTH-1:0] centi_celsius
);
   import tsc_pkg::*;

   logic [15:0] raw;
   logic [15:0] reading;
   logic [7:0]  int_part;
   logic [15:0] int_scaled;
   logic [6:0]  frac_centi;
   logic [15:0] total;

   // Family specific adjustment of the raw 1/16 degree reading.
   always_comb begin
      raw     = {status.temp_high, status.temp_low};
      reading = raw;
      if (family_code == FAMILY_NINE_BIT) begin
         // Half-degree reading extended with count remain: (t & ~1) * 8 + 12 - remain.
         reading = {raw[12:1], 4'b0000} + 16'd12 - {8'h00, status.count_remain};
      end else if (family_code == FAMILY_TWELVE_BIT) begin
         // Clear the bits that the configured resolution leaves undefined.
         priority if (status.resolution[6] && status.resolution[5]) begin
            reading = raw;
         end else if (status.resolution[6]) begin
            reading = raw & 16'hFFFE;
         end else if (status.resolution[5]) begin
            reading = raw & 16'hFFFC;
         end else begin
            reading = raw & 16'hFFF8;
         end
      end
   end

   // Whole degrees times 100 plus the rounded sixteenths.
   always_comb begin
      int_part   = reading[11:4];
      int_scaled = {{8{int_part[7]}}, int_part} * 16'd100;
      frac_centi = (reading[3] ? 7'd50 : 7'd0) + (reading[2] ? 7'd25 : 7'd0)
                 + (reading[1] ? 7'd13 : 7'd0) + (reading[0] ? 7'd6 : 7'd0);
      total      = int_scaled + {9'd0, frac_centi};
      // A failed CRC reports zero.
      centi_celsius = status.crc_ok ? signed'(total[CENTI_WIDTH-1:0]) : '0;
   end

endmodule

>>> hw/rtl/temp_scratchpad_to_centicelsius.sv
// Top level of the 1-Wire scratchpad to centi-Celsius converter.
// Takes one scratchpad byte per transaction and one result per completed
// nine-byte frame, at a sustained rate of one byte per clock cycle. A byte
// accepted into the input register passes the CRC update and conversion
// logic, and the result of a frame's last byte is registered in the output
// register. The input register keeps accepting while a result waits, and
// stalls only when a frame's last byte finds the output register full.
// A frame that fails the CRC gives crc_ok low and a temperature of zero;
// family_code selects the nine-bit extended-resolution or the twelve-bit
// masked conversion, and any other code passes the raw reading through.
module temp_scratchpad_to_centicelsius (
   input  logic        clock,
   input  logic        reset,
   // Configuration: family_code
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,     // [7:0] family_code
   // Scratchpad bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] scratch_byte
   input  logic        req_tuser,    // [0] frame_start
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [14:0] centi_celsius, [15] zero
   output logic        rsp_tuser     // [0] crc_ok
);
   import tsc_pkg::*;

   logic [7:0]                    family_code_ff;
   logic                          in_valid_ff;
   logic                          in_start_ff;
   logic [7:0]                    in_byte_ff;
   logic                          out_valid_ff;
   logic                          out_ok_ff;
   logic signed [CENTI_WIDTH-1:0] out_centi_ff;

   logic                          advance;
   logic                          out_free;
   frame_status_type              status;
   logic signed [CENTI_WIDTH-1:0] centi_celsius;

   // The configuration register takes a write in every cycle.
   assign csr_ready = 1'b1;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         family_code_ff <= FAMILY_TWELVE_BIT;
      end else if (csr_valid && csr_ready) begin
         family_code_ff <= csr_data;
      end
   end

   // The held byte moves on unless it ends a frame and the result slot is busy.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!status.last_byte || out_free);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_start_ff <= req_tuser;
         in_byte_ff  <= req_tdata;
      end
   end

   tsc_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .frame_start  (in_start_ff),
      .scratch_byte (in_byte_ff),
      .status       (status)
   );

   tsc_convert u_convert (
      .family_code   (family_code_ff),
      .status        (status),
      .centi_celsius (centi_celsius)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && status.last_byte) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && status.last_byte) begin
         out_ok_ff    <= status.crc_ok;
         out_centi_ff <= centi_celsius;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_centi_ff};
   assign rsp_tuser  = out_ok_ff;

endmodule

>>> test/tb_temp_scratchpad_to_centicelsius.sv
// Self-checking testbench for the scratchpad to centi-Celsius converter.
`timescale 1ns / 1ps

module tb_temp_scratchpad_to_centicelsius;
   import tsc_pkg::*;

   // Settle time after the block has drained.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 7;
   localparam int BYTES_PER_PHASE = 200;
   localparam int DIRECTED_COUNT = 16;

   // Family codes that select neither conversion.
   localparam logic [7:0] FAMILY_RAW_LOW = 8'h00;
   localparam logic [7:0] FAMILY_RAW_HIGH = 8'hFF;

   // One converted reading as it leaves the block.
   typedef struct packed {
      logic        crc_ok;
      logic [14:0] centi;
   } reading_type;

   // One directed frame: family, leading partial bytes, held bytes, outcome.
   typedef struct packed {
      logic [7:0]         family;
      logic [3:0]         junk_lead;
      logic               start;
      logic [7:0]         temp_lsb;
      logic [7:0]         temp_msb;
      logic [7:0]         resolution;
      logic [7:0]         count_remain;
      logic               bad_crc;
      logic               typed;
      logic               exp_ok;
      logic signed [15:0] exp_centi;
   } frame_row_type;

   localparam frame_row_type DIRECTED_FRAMES [DIRECTED_COUNT] = '{
      // Zero reading with the family left at its reset value.
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b1, 8'h00, 8'h00, 8'h7F, 8'h0C, 1'b0, 1'b1, 1'b1, 16'sd0},
      // Largest and smallest twelve-bit readings.
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b1, 8'hFF, 8'h07, 8'h7F, 8'h0C, 1'b0, 1'b1, 1'b1, 16'sd12794},
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b1, 8'h00, 8'h08, 8'h7F, 8'h0C, 1'b0, 1'b1, 1'b1, -16'sd12800},
      // Integer part wraps to eight bits signed.
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b1, 8'hF0, 8'h7F, 8'h7F, 8'h0C, 1'b0, 1'b1, 1'b1, -16'sd100},
      // Eleven, ten and nine bit resolution masks.
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b1, 8'hFF, 8'hFF, 8'h5F, 8'h0C, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b1, 8'h91, 8'h01, 8'h3F, 8'h0C, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b1, 8'h57, 8'h05, 8'h1F, 8'h0C, 1'b0, 1'b0, 1'b0, 16'sd0},
      // CRC failure reports zero.
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b1, 8'h50, 8'h05, 8'h7F, 8'h0C, 1'b1, 1'b1, 1'b0, 16'sd0},
      // Restart in the middle of a frame discards the partial bytes.
      '{FAMILY_TWELVE_BIT, 4'd5, 1'b1, 8'hA2, 8'h00, 8'h7F, 8'h0C, 1'b0, 1'b0, 1'b0, 16'sd0},
      // A new frame starts after a complete one without the start flag.
      '{FAMILY_TWELVE_BIT, 4'd0, 1'b0, 8'h5E, 8'hFE, 8'h60, 8'h0C, 1'b0, 1'b0, 1'b0, 16'sd0},
      // Nine-bit type with count-remain extension, including wraparound.
      '{FAMILY_NINE_BIT, 4'd0, 1'b1, 8'h32, 8'h00, 8'hFF, 8'h0C, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{FAMILY_NINE_BIT, 4'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{FAMILY_NINE_BIT, 4'd0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{FAMILY_NINE_BIT, 4'd0, 1'b1, 8'hAA, 8'h00, 8'hFF, 8'h10, 1'b1, 1'b1, 1'b0, 16'sd0},
      // Other families pass the raw reading through.
      '{FAMILY_RAW_LOW, 4'd0, 1'b1, 8'hF0, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{FAMILY_RAW_HIGH, 4'd0, 1'b1, 8'h08, 8'h80, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 16'sd0}
   };

   localparam logic [7:0] PHASE_FAMILY [RANDOM_PHASES] = '{
      FAMILY_TWELVE_BIT, FAMILY_NINE_BIT, FAMILY_RAW_LOW, FAMILY_TWELVE_BIT,
      FAMILY_RAW_HIGH, FAMILY_NINE_BIT, FAMILY_TWELVE_BIT
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] scratch_byte
   logic        req_tuser = 1'b0;     // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;            // [14:0] centi_celsius, [15] zero
   logic        rsp_tuser;            // [0] crc_ok

   // Predictor state: configuration and the frame being collected.
   logic [7:0]           family_now = FAMILY_TWELVE_BIT;
   logic [IDX_WIDTH-1:0] frame_pos = '0;
   logic [7:0]           frame_crc = 8'h00;
   logic [7:0]           held_lsb = 8'h00;
   logic [7:0]           held_msb = 8'h00;
   logic [7:0]           held_resolution = 8'h00;
   logic [7:0]           held_count_remain = 8'h00;

   reading_type pending_readings [$];
   int          idle_pct = 0;
   int          rsp_stall_left = 0;
   int          error_count = 0;
   int          bytes_sent = 0;
   int          readings_checked = 0;
   int          crc_fail_seen = 0;
   int          family_writes = 0;

   temp_scratchpad_to_centicelsius dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One byte of the Dallas CRC-8, LSB first.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Converts the held bytes to hundredths of a degree for a given family.
   function automatic logic [14:0] centi_from_reading(input logic [7:0] fam, lsb, msb,
                                                      res, cr);
      logic [15:0] m;
      int          s;
      m = {msb, lsb};
      if (fam == FAMILY_NINE_BIT) begin
         m = (m & 16'hFFFE) << 3;
         m = m + 16'd16 - {8'h00, cr} - 16'd4;
      end else if (fam == FAMILY_TWELVE_BIT) begin
         // Undefined low bits depend on the configured resolution.
         if (res[6:5] != 2'b11) begin
            if (res[6]) m[0] = 1'b0;
            else if (res[5]) m[1:0] = 2'b00;
            else m[2:0] = 3'b000;
         end
      end
      s = int'($signed(m[11:4])) * 100;
      if (m[3]) s += 50;
      if (m[2]) s += 25;
      if (m[1]) s += 13;
      if (m[0]) s += 6;
      return s[14:0];
   endfunction

   // Advances the frame tracker by one byte; reports a reading on the ninth.
   task automatic track_scratch_byte(input logic start, input logic [7:0] b,
                                     output logic produced, output reading_type r);
      if (start) begin
         frame_pos = '0;
         frame_crc = 8'h00;
      end
      frame_crc = crc8_step(frame_crc, b);
      unique case (frame_pos)
         IDX_TEMP_LOW: held_lsb = b;
         IDX_TEMP_HIGH: held_msb = b;
         IDX_RESOLUTION: held_resolution = b;
         IDX_COUNT_REMAIN: held_count_remain = b;
         default: ;
      endcase
      produced = (frame_pos == IDX_LAST);
      r = '0;
      if (produced) begin
         r.crc_ok = (frame_crc == 8'h00);
         r.centi = r.crc_ok ? centi_from_reading(family_now, held_lsb, held_msb,
                                                 held_resolution, held_count_remain) : '0;
         frame_pos = '0;
         frame_crc = 8'h00;
      end else begin
         frame_pos = frame_pos + 1'b1;
      end
   endtask

   // Sends one byte transaction and records the reading it completes, if any.
   task automatic send_byte(input logic start, input logic [7:0] data, input logic typed,
                            input reading_type typed_r);
      logic        produced;
      reading_type r;
      req_tvalid <= 1'b1;
      req_tuser <= start;
      req_tdata <= data;
      do begin
         @(posedge clock);
      end while (!req_tready);
      track_scratch_byte(start, data, produced, r);
      if (produced) pending_readings.push_back(typed ? typed_r : r);
      bytes_sent++;
      // Occasional idle gap in the sender's requests.
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Sends a nine-byte scratchpad with a correct or corrupted CRC byte.
   task automatic send_frame(input logic start, input logic [7:0] lsb, msb, res, cr,
                             input logic bad_crc, input logic typed,
                             input reading_type typed_r);
      logic [7:0] image [9];
      logic [7:0] crc;
      image[0] = lsb;
      image[1] = msb;
      image[2] = 8'($urandom);
      image[3] = 8'($urandom);
      image[4] = res;
      image[5] = 8'($urandom);
      image[6] = cr;
      image[7] = 8'($urandom);
      crc = 8'h00;
      for (int i = 0; i < 8; i++) crc = crc8_step(crc, image[i]);
      image[8] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
      for (int i = 0; i < 9; i++) begin
         send_byte((i == 0) ? start : 1'b0, image[i], typed && (i == 8), typed_r);
      end
   endtask

   // Writes family_code once the block has drained and gone quiet.
   task automatic write_family(input logic [7:0] value);
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      family_now = value;
      family_writes++;
   endtask

   // Result side back-pressure in random bursts.
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares every result transaction with the oldest expected reading.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("Unexpected reading: crc_ok %0b centi_celsius %0d", rsp_tuser,
                   $signed(rsp_tdata[14:0]));
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (!want.crc_ok) crc_fail_seen++;
            if (rsp_tuser !== want.crc_ok) begin
               $error("crc_ok: expected %0b, actual %0b", want.crc_ok, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[14:0] !== want.centi) begin
               $error("centi_celsius: expected %0d, actual %0d", $signed(want.centi),
                      $signed(rsp_tdata[14:0]));
               error_count++;
            end
            if (rsp_tdata[15] !== 1'b0) begin
               $error("rsp_tdata pad bit: expected 0, actual %0b", rsp_tdata[15]);
               error_count++;
            end
         end
      end
   end

   // Stimulus: directed frames, then random phases under several families.
   initial begin
      frame_row_type row;
      reading_type   typed_r;
      int            phase_first;
      int            choice;
      int            noise_len;
      logic [7:0]    msb;
      logic [7:0]    cr;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames, with the family changed only between drained frames.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_FRAMES[i];
         if (row.family != family_now) write_family(row.family);
         for (int j = 0; j < row.junk_lead; j++) send_byte(j == 0, 8'($urandom), 1'b0, '0);
         typed_r.crc_ok = row.exp_ok;
         typed_r.centi = row.exp_centi[14:0];
         send_frame(row.start, row.temp_lsb, row.temp_msb, row.resolution, row.count_remain,
                    row.bad_crc, row.typed, typed_r);
      end

      // Random phases; phases 1, 4 and the last one run without idling on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_family((p == 3) ? 8'($urandom) : PHASE_FAMILY[p]);
         if (p == RANDOM_PHASES - 1 || p % 3 == 1) idle_pct = 0;
         else idle_pct = $urandom_range(10, 40);
         phase_first = bytes_sent;
         while (bytes_sent - phase_first < BYTES_PER_PHASE) begin
            choice = $urandom_range(0, 99);
            msb = $urandom_range(0, 1) ? 8'($urandom) : ($urandom_range(0, 1) ? 8'h00 : 8'hFF);
            cr = $urandom_range(0, 1) ? 8'($urandom_range(0, 16)) : 8'($urandom);
            if (choice < 84) begin
               // Well-formed frame, a few with a broken CRC byte.
               send_frame($urandom_range(0, 3) != 0, 8'($urandom), msb, 8'($urandom), cr,
                          choice >= 72, 1'b0, '0);
            end else begin
               // Truncated frame with stray start flags.
               noise_len = $urandom_range(1, 8);
               for (int k = 0; k < noise_len; k++) begin
                  send_byte((k == 0) ? 1'b1 : ($urandom_range(0, 7) == 0), 8'($urandom),
                            1'b0, '0);
               end
            end
         end
      end

      // Drain and let the pipeline settle.
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d scratchpad bytes over %0d family_code settings.", bytes_sent,
               family_writes + 1);
      $display("Checked %0d readings, %0d of them CRC failures.", readings_checked,
               crc_fail_seen);
      if (error_count == 0) begin
         $display("tb_temp_scratchpad_to_centicelsius: PASS");
      end else begin
         $display("tb_temp_scratchpad_to_centicelsius: FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #400000;
      $display("tb_temp_scratchpad_to_centicelsius: FAIL");
      $finish;
   end

endmodule
